### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define FFHA_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("ffha assertion failed");

// Clocked property, checked through reset as well.
`define FFHA_ASSERT_NORST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("ffha assertion failed");

`endif

### hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int unsigned FIELD_W   = 13;
  localparam int unsigned NEED_W    = 14;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_POW2 = 2'd1;

  localparam logic [FIELD_W-1:0] HEAP_LEN_RST = 13'd4096;

  // Request size rounded to a word multiple, optionally to a power of two first.
  function automatic logic [NEED_W-1:0] round_request(input logic [FIELD_W-1:0] x,
                                                      input logic pow2);
    logic [FIELD_W-1:0] s;
    logic [NEED_W-1:0]  v;
    s = x - 13'd1;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    if (pow2 && (x != '0)) begin
      v = {1'b0, s} + 14'd1;
    end else begin
      v = {1'b0, x};
    end
    return (v + 14'd3) & ~14'd3;
  endfunction

endpackage

### hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with an address-ordered chain of block headers
// kept in a header memory with one write port and one registered read port
// (one read, one write per cycle). An init request lays out one free block
// over heap_len; a free request is a read-modify-write of the header. An
// allocate request walks the chain from the remembered search start at one
// header read per cycle: it takes the request, reads each header visited,
// runs each pass of the walk loop (loop check, two loop exits, merge and fit
// check), writes the split and loads the result register; a failed walk
// skips the split and ends on one last loop check. The header memory read
// port sets the pace of the walk.
// One request is worked on at a time; the next one is taken while a result
// still waits in the output register. No clearing pass after reset: issue an
// init request before allocating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [ffha_pkg::FIELD_W-1:0]      in_request_size,
  input  logic [ffha_pkg::FIELD_W-1:0]      in_free_address,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffha_pkg::FIELD_W-1:0]      out_payload_address,
  output logic                              out_status,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffha_pkg::FIELD_W-1:0]      cfg_data
);

  localparam int unsigned DEPTH  = HEAP_BYTES / 4;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned SW     = AW + 2;
  localparam int unsigned SPAN   = (HEADER_BYTES + 3) / 4 * 4;
  localparam int unsigned CW     = ((SW > ffha_pkg::NEED_W) ? SW : ffha_pkg::NEED_W) + 2;
  localparam int unsigned LW     = ((SW > ffha_pkg::FIELD_W) ? SW : ffha_pkg::FIELD_W) + 1;
  localparam int unsigned BUDGET = 2 * DEPTH + 4;
  localparam int unsigned BW     = $clog2(BUDGET + 1);

  typedef struct packed {
    logic [AW-1:0] link;
    logic [SW-1:0] size;
    logic          used;
  } hdr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT0, S_INIT1, S_FREE, S_OUTER, S_IN1, S_IN2,
    S_MERGE, S_SPLIT0, S_SPLIT1, S_DONE
  } state_t;

  hdr_t mem [DEPTH];
  hdr_t rd_data_r;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  p_r, p_nxt;
  logic [AW-1:0]                  q_r, q_nxt;
  logic [AW-1:0]                  word_r, word_nxt;
  logic [AW-1:0]                  search_r, search_nxt;
  logic [BW-1:0]                  budget_r, budget_nxt;
  logic [ffha_pkg::NEED_W-1:0]    need_r, need_nxt;
  logic [CW-1:0]                  need_span_r, need_span_nxt;
  logic [SW-1:0]                  oldsize_r, oldsize_nxt;
  logic [ffha_pkg::FIELD_W-1:0]   res_addr_r, res_addr_nxt;
  logic                           res_status_r, res_status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ffha_pkg::FIELD_W-1:0]   out_addr_r, out_addr_nxt;
  logic                           out_status_r, out_status_nxt;
  logic [ffha_pkg::FIELD_W-1:0]   heap_len_r, heap_len_nxt;
  logic                           round_pow2_r, round_pow2_nxt;

  logic                           mem_we;
  logic [AW-1:0]                  mem_wa;
  hdr_t                           mem_wd;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;

  logic [LW-1:0]                  len_c, endoff_c, isize_c, fa_c, off_c;
  logic                           free_ok_c;
  logic [ffha_pkg::NEED_W-1:0]    need_c;
  logic [CW-1:0]                  msize_c, nw_c, rem_c, pay_c;
  logic                           fit_c;

  assign in_ready            = (state_r == S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;

  always_comb begin
    len_c = LW'(heap_len_r) & ~LW'(3);
    if (len_c > LW'(4 * DEPTH)) begin
      len_c = LW'(4 * DEPTH);
    end
    if (len_c < LW'(2 * SPAN)) begin
      len_c = LW'(2 * SPAN);
    end
    endoff_c  = len_c - LW'(SPAN);
    isize_c   = len_c - LW'(2 * SPAN);
    fa_c      = LW'(in_free_address);
    off_c     = fa_c - LW'(SPAN);
    free_ok_c = (fa_c >= LW'(SPAN)) && (off_c < LW'(HEAP_BYTES));
    need_c    = ffha_pkg::round_request(in_request_size, round_pow2_r);
    msize_c   = CW'({p_r - q_r, 2'b00}) - CW'(SPAN);
    fit_c     = (msize_c >= need_span_r);
    nw_c      = CW'(q_r) + (need_span_r >> 2);
    rem_c     = CW'(oldsize_r) - need_span_r;
    pay_c     = CW'({q_r, 2'b00}) + CW'(SPAN);
  end

  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    word_nxt       = word_r;
    search_nxt     = search_r;
    budget_nxt     = budget_r;
    need_nxt       = need_r;
    need_span_nxt  = need_span_r;
    oldsize_nxt    = oldsize_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    heap_len_nxt   = heap_len_r;
    round_pow2_nxt = round_pow2_r;
    mem_we         = 1'b0;
    mem_wa         = q_r;
    mem_wd         = '0;
    rd_en          = 1'b0;
    rd_addr        = p_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        ffha_pkg::REG_HEAP_LEN:   heap_len_nxt   = cfg_data;
        ffha_pkg::REG_ROUND_POW2: round_pow2_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt   = '0;
          res_status_nxt = 1'b0;
          case (ffha_pkg::mode_t'(in_mode))
            ffha_pkg::MODE_INIT: state_nxt = S_INIT0;
            ffha_pkg::MODE_ALLOC: begin
              need_nxt      = need_c;
              need_span_nxt = CW'(need_c) + CW'(SPAN);
              p_nxt         = search_r;
              q_nxt         = search_r;
              budget_nxt    = BW'(BUDGET);
              rd_en         = 1'b1;
              rd_addr       = search_r;
              state_nxt     = S_OUTER;
            end
            ffha_pkg::MODE_FREE: begin
              if (free_ok_c) begin
                word_nxt  = off_c[AW+1:2];
                rd_en     = 1'b1;
                rd_addr   = off_c[AW+1:2];
                state_nxt = S_FREE;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT0: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = '{link: endoff_c[AW+1:2], size: isize_c[SW-1:0], used: 1'b0};
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        mem_we     = 1'b1;
        mem_wa     = endoff_c[AW+1:2];
        mem_wd     = '0;
        search_nxt = '0;
        state_nxt  = S_DONE;
      end
      S_FREE: begin
        mem_we     = 1'b1;
        mem_wa     = word_r;
        mem_wd     = '{link: rd_data_r.link, size: rd_data_r.size, used: 1'b0};
        search_nxt = '0;
        state_nxt  = S_DONE;
      end
      S_OUTER: begin
        if ((rd_data_r.link == '0) || (budget_r == '0)) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_IN1;
        end
      end
      S_IN1: begin
        if (rd_data_r.used && (budget_r != '0)) begin
          p_nxt      = rd_data_r.link;
          q_nxt      = rd_data_r.link;
          budget_nxt = budget_r - BW'(1);
          rd_en      = 1'b1;
          rd_addr    = rd_data_r.link;
        end else begin
          state_nxt = S_IN2;
        end
      end
      S_IN2: begin
        if (!rd_data_r.used && (rd_data_r.link != '0) && (budget_r != '0)) begin
          p_nxt      = rd_data_r.link;
          budget_nxt = budget_r - BW'(1);
          rd_en      = 1'b1;
          rd_addr    = rd_data_r.link;
        end else begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        state_nxt = S_OUTER;
        if (p_r > q_r) begin
          mem_we      = 1'b1;
          mem_wa      = q_r;
          mem_wd      = '{link: p_r, size: msize_c[SW-1:0], used: 1'b0};
          oldsize_nxt = msize_c[SW-1:0];
          if (fit_c) begin
            state_nxt = S_SPLIT0;
          end
        end
      end
      S_SPLIT0: begin
        mem_we    = 1'b1;
        mem_wa    = q_r;
        mem_wd    = '{link: nw_c[AW-1:0], size: SW'(need_r), used: 1'b1};
        word_nxt  = nw_c[AW-1:0];
        state_nxt = S_SPLIT1;
      end
      S_SPLIT1: begin
        mem_we       = 1'b1;
        mem_wa       = word_r;
        mem_wd       = '{link: p_r, size: rem_c[SW-1:0], used: 1'b0};
        search_nxt   = q_r;
        res_addr_nxt = pay_c[ffha_pkg::FIELD_W-1:0];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      search_r     <= '0;
      heap_len_r   <= ffha_pkg::HEAP_LEN_RST;
      round_pow2_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      search_r     <= search_nxt;
      heap_len_r   <= heap_len_nxt;
      round_pow2_r <= round_pow2_nxt;
    end
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    word_r       <= word_nxt;
    budget_r     <= budget_nxt;
    need_r       <= need_nxt;
    need_span_r  <= need_span_nxt;
    oldsize_r    <= oldsize_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // header memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffha_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ffha_pkg::FIELD_W-1:0] out_payload_address,
  input logic                         out_status
);

  `FFHA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_payload_address) && $stable(out_status))
  `FFHA_ASSERT(a_fail_zero, clk, rst_n, out_valid && out_status |-> out_payload_address == '0)
  `FFHA_ASSERT(a_busy_after_req, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `FFHA_ASSERT(a_word_aligned, clk, rst_n, out_valid |-> out_payload_address[1:0] == 2'b00)
  `FFHA_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for first_fit_heap_allocator. A short directed plan runs
// first, covering init, field extremes, rounding modes and the out-of-range
// heap lengths. Random phases follow: each sometimes sets the registers, then
// runs an init and a mix of allocate and free requests with some noise. Each
// result must match its plan answer or a bench-side model of the header chain.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned FIELD_W       = ffha_pkg::FIELD_W;
  localparam int unsigned CFG_IDX_W     = ffha_pkg::CFG_IDX_W;
  localparam int unsigned HEAP_BYTES    = 4096;
  localparam int unsigned HEADER_BYTES  = 8;
  localparam int unsigned HDR_SPAN      = (HEADER_BYTES + 3) / 4 * 4;
  localparam int unsigned DEPTH         = HEAP_BYTES / 4;
  localparam int unsigned WORD_W        = $clog2(DEPTH);
  localparam int unsigned WALK_LIMIT    = 2 * DEPTH + 4;
  localparam int unsigned ITEM_TARGET   = 1750;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned FIELD_MAX     = (1 << FIELD_W) - 1;

  typedef struct packed {
    logic [FIELD_W-1:0] payload_address;
    logic               status;
  } heap_result_t;

  typedef enum logic {STEP_REQUEST, STEP_REG_WRITE} step_kind_t;

  typedef enum logic [1:0] {
    READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC
  } ready_style_t;

  typedef struct {
    step_kind_t         kind;
    logic [1:0]         code;
    logic [FIELD_W-1:0] arg_a;
    logic [FIELD_W-1:0] arg_b;
    bit                 has_answer;
    heap_result_t       answer;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_mode = ffha_pkg::MODE_NOP;
  logic [FIELD_W-1:0]   in_request_size = '0;
  logic [FIELD_W-1:0]   in_free_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FIELD_W-1:0]   out_payload_address;
  logic                 out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data = '0;

  // bench copy of the header chain
  logic [WORD_W-1:0]  link_word [DEPTH] = '{default: '0};
  logic [FIELD_W-1:0] block_bytes [DEPTH] = '{default: '0};
  logic               block_used [DEPTH] = '{default: 1'b0};
  bit                 header_written [DEPTH] = '{default: 1'b0};
  logic [WORD_W-1:0]  scan_word = '0;
  logic [FIELD_W-1:0] heap_len_setting = ffha_pkg::HEAP_LEN_RST;
  logic               pow2_setting = 1'b0;

  heap_result_t expected_results [$];
  step_t        plan [$];
  int unsigned  items_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  result_errors = 0;
  int unsigned  ready_left = 0;
  int unsigned  ready_tick = 0;
  ready_style_t ready_style = READY_ALWAYS;

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_free_address    (in_free_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_address(out_payload_address),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'($urandom_range(0, FIELD_MAX));
  endfunction

  function automatic int unsigned rounded_need(input logic [FIELD_W-1:0] size,
                                               input logic pow2);
    int unsigned n;
    n = 32'(size);
    if (pow2 && n != 0) begin
      n = 1;
      while (n < 32'(size)) n = n << 1;
    end
    return (n + 3) & ~32'd3;
  endfunction

  function automatic void write_header(input int unsigned w, input int unsigned link,
                                       input int unsigned bytes, input logic used);
    link_word[w]      = WORD_W'(link);
    block_bytes[w]    = FIELD_W'(bytes);
    block_used[w]     = used;
    header_written[w] = 1'b1;
  endfunction

  function automatic heap_result_t predict_heap_result(input ffha_pkg::mode_t mode,
                                                       input logic [FIELD_W-1:0] size,
                                                       input logic [FIELD_W-1:0] addr);
    heap_result_t res;
    int unsigned  len, endw, need, p, q, budget, oldsize, r, nw;
    bit           found;
    res   = '0;
    found = 1'b0;
    case (mode)
      ffha_pkg::MODE_INIT: begin
        len = 32'(heap_len_setting);
        if (len > HEAP_BYTES) len = HEAP_BYTES;
        len = len & ~32'd3;
        if (len < 2 * HDR_SPAN) len = 2 * HDR_SPAN;
        endw = ((len - HDR_SPAN) / 4) % DEPTH;
        write_header(0, endw, len - 2 * HDR_SPAN, 1'b0);
        write_header(endw, 0, 0, 1'b0);
        scan_word = '0;
      end
      ffha_pkg::MODE_ALLOC: begin
        need   = rounded_need(size, pow2_setting);
        p      = 32'(scan_word);
        q      = p;
        budget = WALK_LIMIT;
        while (link_word[p] != '0 && budget != 0 && !found) begin
          while (block_used[p] && budget != 0) begin
            p = 32'(link_word[p]);
            q = p;
            budget--;
          end
          while (!block_used[p] && link_word[p] != '0 && budget != 0) begin
            p = 32'(link_word[p]);
            budget--;
          end
          if (p > q) begin
            block_bytes[q] = FIELD_W'((p - q) * 4 - HDR_SPAN);
            link_word[q]   = WORD_W'(p);
            if (32'(block_bytes[q]) >= need + HDR_SPAN) found = 1'b1;
          end
        end
        if (found) begin
          oldsize = 32'(block_bytes[q]);
          r       = 32'(link_word[q]);
          nw      = (q + (need + HDR_SPAN) / 4) % DEPTH;
          write_header(q, nw, need, 1'b1);
          write_header(nw, r, oldsize - need - HDR_SPAN, 1'b0);
          scan_word           = WORD_W'(q);
          res.payload_address = FIELD_W'(q * 4 + HDR_SPAN);
        end else begin
          res.status = 1'b1;
        end
      end
      ffha_pkg::MODE_FREE: begin
        if (32'(addr) >= HDR_SPAN && 32'(addr) - HDR_SPAN < HEAP_BYTES) begin
          block_used[((32'(addr) - HDR_SPAN) >> 2) % DEPTH] = 1'b0;
          scan_word = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_step(input step_kind_t kind, input logic [1:0] code,
                                   input int unsigned arg_a,
                                   input int unsigned arg_b,
                                   input bit has_answer = 1'b0,
                                   input int unsigned payload = 0,
                                   input logic status = 1'b0);
    step_t s;
    s.kind                   = kind;
    s.code                   = code;
    s.arg_a                  = FIELD_W'(arg_a);
    s.arg_b                  = FIELD_W'(arg_b);
    s.has_answer             = has_answer;
    s.answer.payload_address = FIELD_W'(payload);
    s.answer.status          = status;
    plan.push_back(s);
  endfunction

  task automatic issue_request(input ffha_pkg::mode_t mode, input logic [FIELD_W-1:0] size,
                               input logic [FIELD_W-1:0] addr, input bit has_answer,
                               input heap_result_t answer, output heap_result_t res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_request_size <= size;
    in_free_address <= addr;
    do @(posedge clk); while (!in_ready);
    res = predict_heap_result(mode, size, addr);
    expected_results.push_back(has_answer ? answer : res);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [FIELD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ffha_pkg::REG_HEAP_LEN) heap_len_setting = data;
    else if (idx == ffha_pkg::REG_ROUND_POW2) pow2_setting = data[0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      ready_left  = $urandom_range(16, 200);
    end
    ready_left--;
    ready_tick++;
    case (ready_style)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:      out_ready <= (ready_tick % 9) < 3;
    endcase
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: payload_address %0d status %0d",
               out_payload_address, out_status);
        result_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_payload_address !== want.payload_address) begin
          $error("payload_address: expected %0d, got %0d",
                 want.payload_address, out_payload_address);
          result_errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          result_errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    heap_result_t       res;
    logic [FIELD_W-1:0] live_blocks [$];
    logic [FIELD_W-1:0] addr;
    logic [FIELD_W-1:0] size;
    int unsigned        pick, w, k, phase_len;

    // init first: the header store holds nothing before it
    add_step(STEP_REQUEST, ffha_pkg::MODE_INIT, 0, 0, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 0, 0, 1, HDR_SPAN, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 1, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, HEAP_BYTES, 0, 1, 0, 1);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, FIELD_MAX, 0, 1, 0, 1);
    add_step(STEP_REQUEST, ffha_pkg::MODE_FREE, 0, 16, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_FREE, 0, 0, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_FREE, 0, FIELD_MAX, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_FREE, 0, 17, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_NOP, FIELD_MAX, FIELD_MAX, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 4, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 8, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_FREE, 0, 16, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_FREE, 0, 28, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 20, 0);
    add_step(STEP_REG_WRITE, ffha_pkg::REG_ROUND_POW2, 1, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 1, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 2, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 5, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 100, 0);
    add_step(STEP_REG_WRITE, ffha_pkg::REG_HEAP_LEN, 0, 0);
    add_step(STEP_REG_WRITE, ffha_pkg::REG_ROUND_POW2, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_INIT, 0, 0, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 0, 0, 1, 0, 1);
    add_step(STEP_REG_WRITE, ffha_pkg::REG_HEAP_LEN, FIELD_MAX, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_INIT, 0, 0, 1, 0, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, HEAP_BYTES - 23, 0, 1, 0, 1);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, HEAP_BYTES - 24, 0, 1, HDR_SPAN, 0);
    add_step(STEP_REQUEST, ffha_pkg::MODE_ALLOC, 0, 0, 1, 0, 1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG_WRITE) begin
        wait_for_results();
        write_register(plan[i].code, plan[i].arg_a);
      end else begin
        issue_request(ffha_pkg::mode_t'(plan[i].code), plan[i].arg_a, plan[i].arg_b,
                      plan[i].has_answer, plan[i].answer, res);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      wait_for_results();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       addr = FIELD_W'($urandom_range(0, 15));
          1:       addr = FIELD_W'($urandom_range(HEAP_BYTES + 1, FIELD_MAX));
          2, 3:    addr = FIELD_W'($urandom_range(1025, HEAP_BYTES));
          default: addr = FIELD_W'($urandom_range(16, 1024));
        endcase
        write_register(ffha_pkg::REG_HEAP_LEN, addr);
      end
      if ($urandom_range(0, 2) == 0) write_register(ffha_pkg::REG_ROUND_POW2, rand_field());
      live_blocks.delete();
      issue_request(ffha_pkg::MODE_INIT, rand_field(), rand_field(), 1'b0, '0, res);
      phase_len = $urandom_range(20, 90);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick >= 48 && pick < 80 && live_blocks.size() == 0) pick = 0;
        if (pick < 48) begin
          size = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(0, heap_len_setting))
                                             : FIELD_W'($urandom_range(0, 60));
          issue_request(ffha_pkg::MODE_ALLOC, size, rand_field(), 1'b0, '0, res);
          if (!res.status) live_blocks.push_back(res.payload_address);
        end else if (pick < 80) begin
          k    = $urandom_range(0, live_blocks.size() - 1);
          addr = live_blocks[k];
          if ($urandom_range(0, 7) == 0) addr = addr + FIELD_W'($urandom_range(1, 3));
          live_blocks.delete(k);
          issue_request(ffha_pkg::MODE_FREE, rand_field(), addr, 1'b0, '0, res);
        end else if (pick < 87) begin
          if ($urandom_range(0, 1)) begin
            do w = $urandom_range(0, DEPTH - 1); while (!header_written[w]);
            addr = FIELD_W'(w * 4 + HDR_SPAN + $urandom_range(0, 3));
          end else if ($urandom_range(0, 1)) begin
            addr = FIELD_W'($urandom_range(0, HDR_SPAN - 1));
          end else begin
            addr = FIELD_W'($urandom_range(HEAP_BYTES + HDR_SPAN, FIELD_MAX));
          end
          issue_request(ffha_pkg::MODE_FREE, rand_field(), addr, 1'b0, '0, res);
        end else if (pick < 91) begin
          issue_request(ffha_pkg::MODE_NOP, rand_field(), rand_field(), 1'b0, '0, res);
        end else if (pick < 93) begin
          live_blocks.delete();
          issue_request(ffha_pkg::MODE_INIT, rand_field(), rand_field(), 1'b0, '0, res);
        end else if (pick < 95) begin
          wait_for_results();
        end else begin
          issue_request(ffha_pkg::MODE_ALLOC, rand_field(), rand_field(), 1'b0, '0, res);
          if (!res.status) live_blocks.push_back(res.payload_address);
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ffha_pkg.sv
hw/rtl/first_fit_heap_allocator.sv
hw/rtl/ffha_checker.sv
tb/testbench.sv
